// File: hw/rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// shared types, codes and the microcode program of the hash table unit
// ----------------------------------------------------------------------------
package lpht_pkg;

  // number of slots; home slot is taken from the low key bits, so a power of two
  localparam int TABLE_SIZE = 8;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  localparam int KEY_W    = 31;
  localparam int AGE_W    = 7;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SEARCH = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY    = 2'd0,
    SLOT_DELETED  = 2'd1,
    SLOT_OCCUPIED = 2'd2
  } slot_state_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_INSERTED  = 3'd0,
    RES_DUPLICATE = 3'd1,
    RES_FULL      = 3'd2,
    RES_FOUND     = 3'd3,
    RES_NOT_FOUND = 3'd4,
    RES_DELETED   = 3'd5
  } result_t;

  // micro-operations driven into the datapath
  typedef enum logic [1:0] {
    UOP_LOAD   = 2'd0,
    UOP_PROBE  = 2'd1,
    UOP_COMMIT = 2'd2
  } uop_t;

  // jump conditions; when the condition holds the jump target is taken
  typedef enum logic [1:0] {
    CND_NEVER    = 2'd0,
    CND_NO_INPUT = 2'd1,
    CND_NOT_DONE = 2'd2,
    CND_OUT_BUSY = 2'd3
  } cond_t;

  typedef logic [1:0] upc_t;

  localparam upc_t STEP_LOAD   = 2'd0;
  localparam upc_t STEP_PROBE  = 2'd1;
  localparam upc_t STEP_COMMIT = 2'd2;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  jump;
    upc_t  next;
  } uword_t;

  // decoded strobes from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic probe;
    logic commit;
  } ctrl_t;

  // status bits the sequencer branches on
  typedef struct packed {
    logic in_valid;
    logic probe_done;
    logic out_busy;
  } seq_flags_t;

  // microcode program
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    case (pc)
      STEP_LOAD:   w = '{op: UOP_LOAD,   cond: CND_NO_INPUT, jump: STEP_LOAD,
                         next: STEP_PROBE};
      STEP_PROBE:  w = '{op: UOP_PROBE,  cond: CND_NOT_DONE, jump: STEP_PROBE,
                         next: STEP_COMMIT};
      STEP_COMMIT: w = '{op: UOP_COMMIT, cond: CND_OUT_BUSY, jump: STEP_COMMIT,
                         next: STEP_LOAD};
      default:     w = '{op: UOP_LOAD,   cond: CND_NEVER,    jump: STEP_LOAD,
                         next: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// open-addressing hash table with linear probing, microcoded control
// ----------------------------------------------------------------------------
// Each input transaction asks to search, insert or delete one key in a table
// of TABLE_SIZE slots and yields exactly one result transaction. The home
// slot is the key modulo TABLE_SIZE and probing walks forward with wrap. An
// operation passes the load step, which takes the item and hashes it, the
// probe step, which visits the probed slots (1 to TABLE_SIZE) one at a time
// through the single read port of the slot table, and the commit step,
// which hands the result to the output register. The output register lets a
// new item be taken while the last result still waits; a further result
// stalls the sequencer until that register is free. Slot states reset to
// empty at once; keys need no reset.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit
  import lpht_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // action [1:0], key [32:2], age [39:33]
  input  logic [39:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // status [2:0], slot_index [5:3], zero pad [7:6]
  output logic [7:0]  m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready
);

  ctrl_t      ctrl;
  seq_flags_t flags;
  logic       probe_done;
  result_t    res_status;
  idx_t       res_where;
  logic       commit_fire;

  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;

  // output register counts as busy only if its result is not taken this cycle
  assign flags.in_valid   = s_tvalid;
  assign flags.probe_done = probe_done;
  assign flags.out_busy   = m_tvalid && !m_tready;

  lpht_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  lpht_slots u_slots (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_valid   (s_tvalid),
    .action     (s_tdata[1:0]),
    .key        (s_tdata[32:2]),
    .age        (s_tdata[39:33]),
    .probe_done (probe_done),
    .res_status (res_status),
    .res_where  (res_where)
  );

  // input is taken only in the load step of the program
  assign s_tready = ctrl.load;

  assign commit_fire = ctrl.commit && !flags.out_busy;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // slot number goes out as its low bits
  always_ff @(posedge clk) begin
    if (commit_fire) begin
      out_status <= res_status;
      out_slot   <= SLOT_W'(res_where);
    end
  end

  assign m_tdata = {2'b00, out_slot, out_status};

  // exactly one micro-operation is active in every step
  a_one_uop : assert property (@(posedge clk) disable iff (rst)
    $onehot({ctrl.load, ctrl.probe, ctrl.commit}))
    else $error("control word decodes to more or less than one operation");

  // an accepted transaction always goes straight to probing
  a_load_to_probe : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ctrl.probe)
    else $error("probe step did not follow an accepted transaction");

  // a finished probe leads to the commit step
  a_probe_to_commit : assert property (@(posedge clk) disable iff (rst)
    (ctrl.probe && probe_done) |=> ctrl.commit)
    else $error("commit step did not follow the end of a probe");

  // a committed result is presented on the next cycle
  a_commit_shows : assert property (@(posedge clk) disable iff (rst)
    commit_fire |=> (m_tvalid && ctrl.load))
    else $error("committed result not presented or sequencer not back to load");

endmodule

// File: hw/rtl/lpht_useq.sv
// ----------------------------------------------------------------------------
// lpht_useq
// micro-program counter and control store of the hash table unit
// ----------------------------------------------------------------------------
module lpht_useq
  import lpht_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  seq_flags_t flags,
  output ctrl_t      ctrl
);

  upc_t   upc;
  upc_t   upc_next;
  uword_t uword;
  logic   take_jump;

  assign uword = ucode_rom(upc);

  always_comb begin
    case (uword.cond)
      CND_NEVER:    take_jump = 1'b0;
      CND_NO_INPUT: take_jump = !flags.in_valid;
      CND_NOT_DONE: take_jump = !flags.probe_done;
      CND_OUT_BUSY: take_jump = flags.out_busy;
      default:      take_jump = 1'b0;
    endcase
    upc_next = take_jump ? uword.jump : uword.next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_LOAD;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    ctrl.load   = (uword.op == UOP_LOAD);
    ctrl.probe  = (uword.op == UOP_PROBE);
    ctrl.commit = (uword.op == UOP_COMMIT);
  end

endmodule

// File: hw/rtl/lpht_slots.sv
// ----------------------------------------------------------------------------
// lpht_slots
// slot table, probe pointer and per-slot decision logic
// ----------------------------------------------------------------------------
module lpht_slots
  import lpht_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  input  logic                in_valid,
  input  logic [ACTION_W-1:0] action,
  input  logic [KEY_W-1:0]    key,
  input  logic [AGE_W-1:0]    age,
  output logic                probe_done,
  output result_t             res_status,
  output idx_t                res_where
);

  slot_state_t            slot_state [TABLE_SIZE];
  logic [KEY_W-1:0]       slot_key   [TABLE_SIZE];
  logic [AGE_W-1:0]       slot_age   [TABLE_SIZE];

  logic [ACTION_W-1:0]    item_action;
  logic [KEY_W-1:0]       item_key;
  logic [AGE_W-1:0]       item_age;
  idx_t                   pos;
  idx_t                   cnt;

  slot_state_t            cur_state;
  logic                   key_eq;
  logic                   last_probe;
  logic                   hit;
  logic                   wr;
  slot_state_t            wr_state;
  result_t                status_now;

  assign cur_state  = slot_state[pos];
  assign key_eq     = (slot_key[pos] == item_key);
  assign last_probe = (cnt == idx_t'(TABLE_SIZE - 1));

  // decision for the slot under the probe pointer
  always_comb begin
    probe_done = 1'b0;
    hit        = 1'b0;
    wr         = 1'b0;
    wr_state   = SLOT_OCCUPIED;
    status_now = RES_NOT_FOUND;
    if (item_action == ACT_INSERT) begin
      if (cur_state != SLOT_OCCUPIED) begin
        probe_done = 1'b1;
        hit        = 1'b1;
        wr         = 1'b1;
        status_now = RES_INSERTED;
      end else if (key_eq) begin
        probe_done = 1'b1;
        status_now = RES_DUPLICATE;
      end else if (last_probe) begin
        probe_done = 1'b1;
        status_now = RES_FULL;
      end
    end else begin
      if (cur_state == SLOT_EMPTY) begin
        probe_done = 1'b1;
      end else if (cur_state == SLOT_OCCUPIED && key_eq) begin
        probe_done = 1'b1;
        hit        = 1'b1;
        if (item_action == ACT_DELETE) begin
          wr         = 1'b1;
          wr_state   = SLOT_DELETED;
          status_now = RES_DELETED;
        end else begin
          status_now = RES_FOUND;
        end
      end else if (last_probe) begin
        probe_done = 1'b1;
      end
    end
  end

  // item capture and probe walk
  always_ff @(posedge clk) begin
    if (ctrl.load && in_valid) begin
      item_action <= action;
      item_key    <= key;
      item_age    <= age;
      pos         <= key[IDX_W-1:0];
      cnt         <= '0;
    end else if (ctrl.probe && !probe_done) begin
      pos <= (pos == idx_t'(TABLE_SIZE - 1)) ? '0 : pos + idx_t'(1);
      cnt <= cnt + idx_t'(1);
    end
    if (ctrl.probe && probe_done) begin
      res_status <= status_now;
      res_where  <= hit ? pos : '0;
    end
  end

  // slot states clear on reset, keys and payloads only matter once written
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slot_state[i] <= SLOT_EMPTY;
      end
    end else if (ctrl.probe && probe_done && wr) begin
      slot_state[pos] <= wr_state;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.probe && probe_done && wr && item_action == ACT_INSERT) begin
      slot_key[pos] <= item_key;
      slot_age[pos] <= item_age;
    end
  end

endmodule

// File: tb/lpht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// shadow hash table that predicts each result and checks the output channel
// ----------------------------------------------------------------------------
module lpht_checker
  import lpht_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // action [1:0], key [32:2], age [39:33]
  input  logic [39:0] s_tdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // status [2:0], slot_index [5:3], zero pad [7:6]
  input  logic [7:0]  m_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  output int          errors,
  output int          results_seen,
  output int          outstanding
);

  typedef struct packed {
    result_t           status;
    logic [SLOT_W-1:0] slot;
  } answer_t;

  slot_state_t      shadow_state [TABLE_SIZE];
  logic [KEY_W-1:0] shadow_key   [TABLE_SIZE];
  answer_t          answer_q [$];

  // walks the shadow table the way the unit does and applies any update
  function automatic answer_t probe_table(input action_t act, input logic [KEY_W-1:0] key);
    answer_t ans;
    int      pos;
    bit      hit;
    ans.status = (act == ACT_INSERT) ? RES_FULL : RES_NOT_FOUND;
    ans.slot   = '0;
    hit        = 1'b0;
    pos        = int'(key % TABLE_SIZE);
    if (act == ACT_INSERT) begin
      for (int n = 0; n < TABLE_SIZE; n++) begin
        // empty and tombstone slots are both free for insert
        if (shadow_state[pos] != SLOT_OCCUPIED) begin
          shadow_state[pos] = SLOT_OCCUPIED;
          shadow_key[pos]   = key;
          ans.status        = RES_INSERTED;
          ans.slot          = SLOT_W'(pos);
          break;
        end
        if (shadow_key[pos] == key) begin
          ans.status = RES_DUPLICATE;
          break;
        end
        pos = (pos + 1) % TABLE_SIZE;
      end
    end else begin
      // search, delete and the unused code all look up the key
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (shadow_state[pos] == SLOT_EMPTY) break;
        if (shadow_state[pos] == SLOT_OCCUPIED && shadow_key[pos] == key) begin
          hit = 1'b1;
          break;
        end
        pos = (pos + 1) % TABLE_SIZE;
      end
      if (hit) begin
        ans.slot = SLOT_W'(pos);
        if (act == ACT_DELETE) begin
          shadow_state[pos] = SLOT_DELETED;
          ans.status        = RES_DELETED;
        end else begin
          ans.status = RES_FOUND;
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    answer_t got;
    if (rst) begin
      foreach (shadow_state[i]) begin
        shadow_state[i] = SLOT_EMPTY;
        shadow_key[i]   = '0;
      end
      answer_q.delete();
      errors       = 0;
      results_seen = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = result_t'(m_tdata[2:0]);
        got.slot   = m_tdata[5:3];
        results_seen++;
        if (answer_q.size() == 0) begin
          $display("%0t: result with none expected: status %0d slot %0d",
                   $time, got.status, got.slot);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                     $time, want.slot, got.slot);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        answer_q.push_back(probe_table(action_t'(s_tdata[1:0]), s_tdata[32:2]));
    end
    outstanding = answer_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the linear probing hash table unit
// ----------------------------------------------------------------------------
// A short directed sequence walks through probing past collisions, wrap at
// the table end, tombstones, a second copy of a key stored in a freed
// slot, a full table and the unused action code. Random traffic then works a
// small pool of clustered keys so that chains grow long, the table fills and
// drains, and duplicates and deletes hit often. Four idling phases vary the
// sender gaps and receiver stalls; the checker holds the expected results.
// ----------------------------------------------------------------------------
module tb_top;
  import lpht_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASES       = 4;
  localparam int SETTLE       = 30;   // idle time after the last drain
  localparam int POOL_MAX     = 16;

  // action code with no operation of its own, handled as a search
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic [39:0] s_tdata  = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;

  int errors;
  int results_seen;
  int outstanding;

  int items_sent     = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // working set of keys for the random part
  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int               pool_n;

  linear_probe_hash_table_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  lpht_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tdata      (s_tdata),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .m_tdata      (m_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .errors       (errors),
    .results_seen (results_seen),
    .outstanding  (outstanding)
  );

  always #10 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // one input transaction, with a random gap ahead of it
  task automatic send_op(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
                         input logic [AGE_W-1:0] age);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {age, key, act};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // hold the sender off until every result has come back
  task automatic drain;
    s_tvalid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  // keys mostly share a few neighboring home slots so chains collide and wrap
  function automatic logic [KEY_W-1:0] pick_key(input int home_base);
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    case ($urandom_range(9))
      0: ;  // anywhere in the key range
      1: k = $urandom_range(1) ? KEY_MAX : '0;
      default: k[IDX_W-1:0] = IDX_W'((home_base + $urandom_range(2)) % TABLE_SIZE);
    endcase
    return k;
  endfunction

  task automatic refill_pool;
    int home_base;
    home_base = $urandom_range(TABLE_SIZE - 1);
    pool_n    = $urandom_range(5, POOL_MAX - 2);
    for (int i = 0; i < pool_n; i++) key_pool[i] = pick_key(home_base);
  endtask

  task automatic send_random;
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    key;
    int                  r;
    r = $urandom_range(99);
    if (r < 5)       act = ACT_UNUSED;
    else if (r < 42) act = ACT_INSERT;
    else if (r < 72) act = ACT_DELETE;
    else             act = ACT_SEARCH;
    // an occasional stray key misses the pool entirely
    if ($urandom_range(9) == 0) key = KEY_W'($urandom);
    else                        key = key_pool[$urandom_range(pool_n - 1)];
    send_op(act, key, AGE_W'($urandom));
  endtask

  initial begin
    int per_phase;
    per_phase = RANDOM_ITEMS / PHASES;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, probing, wrap, tombstones, full table
    send_op(ACT_SEARCH, '0, '0);             // miss on an empty table
    send_op(ACT_INSERT, '0, '0);             // slot 0
    send_op(ACT_INSERT, KEY_MAX, '1);        // home slot 7
    send_op(ACT_INSERT, 31'd8, 7'd5);        // collides at 0, lands in 1
    send_op(ACT_INSERT, 31'd15, 7'd9);       // collides at 7, wraps to 2
    send_op(ACT_SEARCH, 31'd15, '1);         // found after wrap
    send_op(ACT_UNUSED, 31'd15, '0);         // unused code acts as search
    send_op(ACT_DELETE, 31'd8, '0);          // tombstone in slot 1
    send_op(ACT_SEARCH, 31'd15, '0);         // steps over the tombstone
    send_op(ACT_INSERT, 31'd15, 7'd33);      // second copy in the freed slot
    send_op(ACT_DELETE, 31'd15, '0);         // removes the nearer copy
    send_op(ACT_SEARCH, 31'd15, '0);         // the older copy is still there
    send_op(ACT_INSERT, 31'd3, 7'd1);
    send_op(ACT_INSERT, 31'd4, 7'd2);
    send_op(ACT_INSERT, 31'd5, 7'd3);
    send_op(ACT_INSERT, 31'd6, 7'd4);
    send_op(ACT_INSERT, 31'd16, 7'd64);      // last free slot, table now full
    send_op(ACT_INSERT, 31'd100, 7'd7);      // full table
    send_op(ACT_INSERT, 31'd4, 7'd8);        // duplicate
    send_op(ACT_SEARCH, 31'd99, '0);         // probes every slot, misses
    send_op(ACT_DELETE, 31'd99, '0);         // delete of a missing key
    send_op(ACT_DELETE, KEY_MAX, '0);        // delete at the last slot
    drain();

    // random traffic across the idling phases
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int i = 0; i < per_phase; i++) begin
        if (i % 50 == 0) refill_pool();
        if (i == per_phase / 2) drain();
        send_random();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_useq.sv
hw/rtl/lpht_slots.sv
hw/rtl/linear_probe_hash_table_unit.sv
tb/lpht_checker.sv
tb/tb_top.sv
